// ===== rtl/core/bond_adjacency_table_unit_macros.svh =====
// assertion macros shared by the checker
`ifndef BOND_ADJACENCY_TABLE_UNIT_MACROS_SVH
`define BOND_ADJACENCY_TABLE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bat_pkg.sv =====
`default_nettype none

package bat_pkg;

  localparam int MAX_ATOMS  = 64;
  localparam int MAX_DEGREE = 8;
  localparam int MAX_BONDS  = 256;

  localparam int ATOM_W   = $clog2(MAX_ATOMS);
  localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
  localparam int IDX_W    = $clog2(MAX_DEGREE);
  localparam int CNT_W    = $clog2(MAX_BONDS + 1);
  localparam int BOND_W   = 8;
  localparam int CFG_W    = 7;
  localparam int STATUS_W = 3;
  localparam int NBR_AW   = ATOM_W + IDX_W;
  localparam int NBR_DW   = ATOM_W + BOND_W;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_PAIR  = 2'd1,
    OP_LIST  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_RANGE      = 3'd2,
    ST_LIST_FULL  = 3'd3,
    ST_BONDS_FULL = 3'd4
  } status_t;

  // how the result register is filled
  typedef enum logic [1:0] {
    RK_ZERO = 2'd0,
    RK_ADD  = 2'd1,
    RK_PAIR = 2'd2,
    RK_LIST = 2'd3
  } rkind_t;

  typedef struct packed {
    logic    latch;
    logic    deg_rd_a;
    logic    deg_rd_b;
    logic    lat_deg_a;
    logic    lat_deg_b;
    logic    clear;
    logic    wr_a;
    logic    wr_b;
    logic    idx_clr;
    logic    scan_issue;
    logic    list_issue;
    logic    out_load;
    rkind_t  out_kind;
    status_t out_status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic a_ok;
    logic b_ok;
    logic same;
    logic bonds_full;
    logic room_ok;
    logic deg_a_zero;
    logic hit;
    logic idx_end;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bat_ram.sv =====
`default_nettype none

module bat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/bat_ctrl.sv =====
`default_nettype none

module bat_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bat_pkg::stat_t stat,
  output bat_pkg::cmd_t  cmd
);

  import bat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DEG_B,
    S_CHECK,
    S_WR_A,
    S_WR_B,
    S_SCAN,
    S_LIST_RD,
    S_LIST_OUT,
    S_EMIT
  } state_t;

  state_t  state_r, state_nxt;
  rkind_t  kind_r, kind_nxt;
  status_t status_r, status_nxt;
  logic    in_ready_r;

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.out_kind   = kind_r;
    cmd.out_status = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.deg_rd_a = 1'b1;
        state_nxt    = S_DEG_B;
      end
      S_DEG_B: begin
        cmd.lat_deg_a = 1'b1;
        cmd.deg_rd_b  = 1'b1;
        state_nxt     = S_CHECK;
      end
      S_CHECK: begin
        cmd.lat_deg_b = 1'b1;
        cmd.idx_clr   = 1'b1;
        kind_nxt      = RK_ZERO;
        status_nxt    = ST_OK;
        state_nxt     = S_EMIT;
        case (stat.op)
          OP_CLEAR: begin
            cmd.clear = 1'b1;
          end
          OP_LIST: begin
            if (!stat.a_ok) begin
              status_nxt = ST_RANGE;
            end else if (!stat.deg_a_zero) begin
              state_nxt = S_LIST_RD;
            end
          end
          OP_PAIR: begin
            if (!stat.a_ok || !stat.b_ok) begin
              status_nxt = ST_RANGE;
            end else if (stat.same) begin
              kind_nxt   = RK_PAIR;
              status_nxt = ST_NOT_FOUND;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          OP_ADD: begin
            if (!stat.a_ok || !stat.b_ok) begin
              status_nxt = ST_RANGE;
            end else if (stat.bonds_full) begin
              status_nxt = ST_BONDS_FULL;
            end else if (!stat.room_ok) begin
              status_nxt = ST_LIST_FULL;
            end else begin
              state_nxt = S_WR_A;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_WR_A: begin
        cmd.wr_a  = 1'b1;
        state_nxt = S_WR_B;
      end
      S_WR_B: begin
        cmd.wr_b   = 1'b1;
        kind_nxt   = RK_ADD;
        status_nxt = ST_OK;
        state_nxt  = S_EMIT;
      end
      S_SCAN: begin
        if (stat.hit) begin
          kind_nxt   = RK_PAIR;
          status_nxt = ST_OK;
          state_nxt  = S_EMIT;
        end else if (stat.idx_end) begin
          kind_nxt   = RK_PAIR;
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_EMIT;
        end else begin
          cmd.scan_issue = 1'b1;
        end
      end
      S_LIST_RD: begin
        cmd.list_issue = 1'b1;
        state_nxt      = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        cmd.out_kind   = RK_LIST;
        cmd.out_status = ST_OK;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = stat.idx_end ? S_IDLE : S_LIST_RD;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      kind_r     <= RK_ZERO;
      status_r   <= ST_OK;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      kind_r     <= kind_nxt;
      status_r   <= status_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

`default_nettype wire

// ===== rtl/core/bat_dp.sv =====
`default_nettype none

module bat_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bat_pkg::cmd_t                 cmd,
  output bat_pkg::stat_t                stat,
  input  logic                          cfg_wr_en,
  input  logic [bat_pkg::CFG_W-1:0]     cfg_wr_data,
  input  bat_pkg::op_t                  in_op,
  input  logic [bat_pkg::ATOM_W-1:0]    in_first,
  input  logic [bat_pkg::ATOM_W-1:0]    in_second,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bat_pkg::status_t              out_status,
  output logic [bat_pkg::DEG_W-1:0]     out_degree,
  output logic [bat_pkg::ATOM_W-1:0]    out_nbr,
  output logic [bat_pkg::BOND_W-1:0]    out_bond,
  output logic                          out_last
);

  import bat_pkg::*;

  logic [CFG_W-1:0]     cfg_atoms_r, lim;
  op_t                  op_r;
  logic [ATOM_W-1:0]    a_r, b_r;
  logic [DEG_W-1:0]     deg_a_r, deg_b_r, deg_q_live, deg_a_p1, deg_a_p2;
  logic [DEG_W-1:0]     idx_r;
  logic [CNT_W-1:0]     bonds_r;
  logic [MAX_ATOMS-1:0] deg_vld_r;
  logic                 deg_vld_q_r;
  logic                 scan_pend_r;
  logic                 self_bond;

  // degree store
  logic                 deg_we, deg_re;
  logic [ATOM_W-1:0]    deg_waddr, deg_raddr;
  logic [DEG_W-1:0]     deg_wdata, deg_q;

  // neighbor and bond store, one word per entry
  logic                 nbr_we, nbr_re;
  logic [NBR_AW-1:0]    nbr_waddr, nbr_raddr;
  logic [NBR_DW-1:0]    nbr_wdata, nbr_q;
  logic [ATOM_W-1:0]    nb_q;
  logic [BOND_W-1:0]    bond_q, bond_cur;

  logic                 out_valid_r, out_last_r;
  status_t              out_status_r;
  logic [DEG_W-1:0]     out_degree_r;
  logic [ATOM_W-1:0]    out_nbr_r;
  logic [BOND_W-1:0]    out_bond_r;

  assign self_bond  = (a_r == b_r);
  assign deg_a_p1   = deg_a_r + DEG_W'(1);
  assign deg_a_p2   = deg_a_r + DEG_W'(2);
  assign deg_q_live = deg_vld_q_r ? deg_q : '0;
  assign bond_cur   = bonds_r[BOND_W-1:0];
  assign nb_q       = nbr_q[NBR_DW-1:BOND_W];
  assign bond_q     = nbr_q[BOND_W-1:0];
  assign lim        = (cfg_atoms_r > CFG_W'(MAX_ATOMS)) ? CFG_W'(MAX_ATOMS) : cfg_atoms_r;

  assign deg_re    = cmd.deg_rd_a || cmd.deg_rd_b;
  assign deg_raddr = cmd.deg_rd_b ? b_r : a_r;
  assign deg_we    = cmd.wr_a || cmd.wr_b;
  assign deg_waddr = (cmd.wr_b && !self_bond) ? b_r : a_r;
  always_comb begin
    if (cmd.wr_a) begin
      deg_wdata = deg_a_p1;
    end else if (self_bond) begin
      deg_wdata = deg_a_p2;
    end else begin
      deg_wdata = deg_b_r + DEG_W'(1);
    end
  end

  assign nbr_we = cmd.wr_a || cmd.wr_b;
  always_comb begin
    if (cmd.wr_a) begin
      nbr_waddr = {a_r, deg_a_r[IDX_W-1:0]};
      nbr_wdata = {b_r, bond_cur};
    end else if (self_bond) begin
      nbr_waddr = {a_r, deg_a_p1[IDX_W-1:0]};
      nbr_wdata = {a_r, bond_cur};
    end else begin
      nbr_waddr = {b_r, deg_b_r[IDX_W-1:0]};
      nbr_wdata = {a_r, bond_cur};
    end
  end
  assign nbr_re    = cmd.scan_issue || cmd.list_issue;
  assign nbr_raddr = {a_r, idx_r[IDX_W-1:0]};

  bat_ram #(.WIDTH(DEG_W), .DEPTH(MAX_ATOMS)) u_deg_ram (
    .clk     (clk),
    .wr_en   (deg_we),
    .wr_addr (deg_waddr),
    .wr_data (deg_wdata),
    .rd_en   (deg_re),
    .rd_addr (deg_raddr),
    .rd_data (deg_q)
  );

  bat_ram #(.WIDTH(NBR_DW), .DEPTH(MAX_ATOMS * MAX_DEGREE)) u_nbr_ram (
    .clk     (clk),
    .wr_en   (nbr_we),
    .wr_addr (nbr_waddr),
    .wr_data (nbr_wdata),
    .rd_en   (nbr_re),
    .rd_addr (nbr_raddr),
    .rd_data (nbr_q)
  );

  always_comb begin
    stat            = '0;
    stat.op         = op_r;
    stat.a_ok       = CFG_W'(a_r) < lim;
    stat.b_ok       = CFG_W'(b_r) < lim;
    stat.same       = self_bond;
    stat.bonds_full = bonds_r >= CNT_W'(MAX_BONDS);
    stat.room_ok    = self_bond ? (deg_a_p2 <= DEG_W'(MAX_DEGREE))
                                : ((deg_a_r < DEG_W'(MAX_DEGREE)) &&
                                   (deg_q_live < DEG_W'(MAX_DEGREE)));
    stat.deg_a_zero = (deg_a_r == '0);
    stat.hit        = scan_pend_r && (nb_q == b_r);
    stat.idx_end    = (idx_r == deg_a_r);
    stat.out_free   = !out_valid_r || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_atoms_r <= '0;
      bonds_r     <= '0;
      deg_vld_r   <= '0;
      scan_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_atoms_r <= cfg_wr_data;
      end
      if (cmd.clear) begin
        bonds_r   <= '0;
        deg_vld_r <= '0;
      end else begin
        if (deg_we) begin
          deg_vld_r[deg_waddr] <= 1'b1;
        end
        if (cmd.out_load && cmd.out_kind == RK_ADD) begin
          bonds_r <= bonds_r + CNT_W'(1);
        end
      end
      scan_pend_r <= cmd.scan_issue;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_op;
      a_r  <= in_first;
      b_r  <= in_second;
    end
    if (deg_re) begin
      deg_vld_q_r <= deg_vld_r[deg_raddr];
    end
    if (cmd.lat_deg_a) begin
      deg_a_r <= deg_q_live;
    end
    if (cmd.lat_deg_b) begin
      deg_b_r <= deg_q_live;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (nbr_re) begin
      idx_r <= idx_r + DEG_W'(1);
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      // list entries mark only the final one, every other item has one result
      out_last_r   <= (cmd.out_kind == RK_LIST) ? stat.idx_end : 1'b1;
      case (cmd.out_kind)
        RK_ZERO: begin
          out_degree_r <= '0;
          out_nbr_r    <= '0;
          out_bond_r   <= '0;
        end
        RK_ADD: begin
          out_degree_r <= self_bond ? deg_a_p2 : deg_a_p1;
          out_nbr_r    <= b_r;
          out_bond_r   <= bond_cur;
        end
        RK_PAIR: begin
          out_degree_r <= deg_a_r;
          out_nbr_r    <= b_r;
          out_bond_r   <= (cmd.out_status == ST_OK) ? bond_q : '0;
        end
        RK_LIST: begin
          out_degree_r <= deg_a_r;
          out_nbr_r    <= nb_q;
          out_bond_r   <= bond_q;
        end
        default: begin
          out_degree_r <= '0;
          out_nbr_r    <= '0;
          out_bond_r   <= '0;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_degree = out_degree_r;
  assign out_nbr    = out_nbr_r;
  assign out_bond   = out_bond_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/core/bond_adjacency_table_unit.sv =====
// channel | dir | item fields (lsb first)                         | handshake
// in      | in  | tuser: opcode; tdata: first_atom, second_atom   | in_tvalid/in_tready
// out     | out | tdata: status, degree, neighbor_atom, bond_no.  | out_tvalid/out_tready
//         |     | tlast: last result of the item                  |
// cfg     | in  | wr_data: atoms_in_use                           | cfg_wr_en, no wait
//
// one item at a time; every item passes through accept, two degree reads and the check
// add bond: then two store writes; clear and errors: straight to the result
// pair query: scans the stored neighbors of the first atom, one store read
// per cycle; a hit ends the scan early, an atom paired with itself skips the scan
// list query: per neighbor, the neighbor store read and the result load alternate;
// an empty list gives one zeroed result
// out stalls hold the result register and the sequencer; the next item waits in in_tvalid
// rst_n clears degrees (valid bits), bond counter and atoms_in_use; no clearing pass
`default_nettype none

module bond_adjacency_table_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [1:0]                    in_tuser,    // opcode
  input  logic [15:0]                   in_tdata,    // first_atom, second_atom, zero pad
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,   // status, degree, neighbor_atom,
                                                     // bond_number, zero pad
  output logic                          out_tlast,   // last result of the item
  input  logic                          cfg_wr_en,
  input  logic [bat_pkg::CFG_W-1:0]     cfg_wr_data  // atoms_in_use
);

  import bat_pkg::*;

  localparam int OUT_USED = STATUS_W + DEG_W + ATOM_W + BOND_W;

  cmd_t                cmd;
  stat_t               stat;
  status_t             res_status;
  logic [DEG_W-1:0]    res_degree;
  logic [ATOM_W-1:0]   res_nbr;
  logic [BOND_W-1:0]   res_bond;

  // sequencer: decides each step of an item from the datapath status
  bat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stores, counters, range and room checks, result register
  bat_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_op       (op_t'(in_tuser)),
    .in_first    (in_tdata[ATOM_W-1:0]),
    .in_second   (in_tdata[2*ATOM_W-1:ATOM_W]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (res_status),
    .out_degree  (res_degree),
    .out_nbr     (res_nbr),
    .out_bond    (res_bond),
    .out_last    (out_tlast)
  );

  // pack result fields, status in the low bits
  assign out_tdata = {{(24 - OUT_USED){1'b0}}, res_bond, res_nbr, res_degree, res_status};

endmodule

`default_nettype wire

// ===== rtl/core/bat_checker.sv =====
`default_nettype none
`include "bond_adjacency_table_unit_macros.svh"

module bat_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [23:0]               out_tdata,
  input logic                      out_tlast
);

  import bat_pkg::*;

  logic [STATUS_W-1:0] st;
  logic [DEG_W-1:0]    deg;
  logic                err;

  assign st  = out_tdata[STATUS_W-1:0];
  assign deg = out_tdata[STATUS_W+DEG_W-1:STATUS_W];
  assign err = (st == ST_RANGE) || (st == ST_LIST_FULL) || (st == ST_BONDS_FULL);

  // a stalled result holds
  `BAT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed under stall")

  // errors carry one zeroed result
  `BAT_ASSERT_NOW(a_err_zero, out_tvalid && err, out_tlast && out_tdata[23:STATUS_W] == '0, "error result not zeroed")

  // only list streams have more than one result
  `BAT_ASSERT_NOW(a_mid_list, out_tvalid && !out_tlast, st == ST_OK && deg != '0, "bad non-final result")

  // degree never exceeds the list size
  `BAT_ASSERT_NOW(a_deg_max, out_tvalid, deg <= DEG_W'(MAX_DEGREE), "degree above maximum")

  // no new item is taken while results of the current one are still due
  `BAT_ASSERT_NOW(a_no_accept_mid, out_tvalid && !out_tlast, !in_tready, "input taken mid stream")

endmodule

bind bond_adjacency_table_unit bat_checker u_bat_checker (.*);

`default_nettype wire
